// ===== hw/rtl/sorted_key_table_core_assert.svh =====
// Assertion macros for the sorted key table core.
// Define NO_ASSERTIONS to compile the checks away; no other dependencies.
`ifndef SORTED_KEY_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_TABLE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, held off during reset
`define SKT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_key_table_core: check failed");
// Next-cycle implication, held off during reset
`define SKT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_key_table_core: check failed");
`else
`define SKT_ASSERT_IMP(label, clk, rst, ante, cons)
`define SKT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/skt_pkg.sv =====
// Shared constants, codes and types of the sorted key table core.
// No dependencies; used by skt_cell, skt_reduce and sorted_key_table_core.
`default_nettype none
package skt_pkg;

  // Table size and stored payload width
  localparam int CAPACITY     = 64;
  localparam int PAYLOAD_BITS = 16;

  // Port widths fixed by the word format
  localparam int KEY_W       = 64;
  localparam int PAY_IN_W    = 16;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int POS_OUT_W   = 6;
  localparam int COUNT_OUT_W = 7;

  // Internal widths
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Reduction grouping: cells per first-stage group
  localparam int GRP  = 8;
  localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

  typedef logic [KEY_W-1:0]        key_t;
  typedef logic [PAYLOAD_BITS-1:0] pay_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic cmp;  // latch compare flags against the held key
    logic ins;  // apply insert shift
    logic rem;  // apply remove shift
  } skt_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/skt_cell.sv =====
// One slot of the sorted table: key and payload, compare flags, shift logic.
// Depends on skt_pkg.
`default_nettype none
module skt_cell import skt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  skt_ctrl_t ctrl,
  input  logic      occ,
  input  key_t      key_new,
  input  pay_t      pay_new,
  input  logic      prev_lt,
  input  key_t      prev_key,
  input  pay_t      prev_pay,
  input  key_t      next_key,
  input  pay_t      next_pay,
  output key_t      key_q,
  output pay_t      pay_q,
  output logic      lt,
  output logic      eq,
  output logic      bnd
);

  // first slot whose key is not below the searched key
  assign bnd = !lt && prev_lt;

  // compare flags, masked to occupied slots
  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      eq <= 1'b0;
    end else if (ctrl.cmp) begin
      lt <= occ && (key_q < key_new);
      eq <= occ && (key_q == key_new);
    end
  end

  // storage: shift right on insert, left on remove, from the boundary on
  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      if (prev_lt) begin
        key_q <= key_new;
        pay_q <= pay_new;
      end else begin
        key_q <= prev_key;
        pay_q <= prev_pay;
      end
    end else if (ctrl.rem && !lt) begin
      key_q <= next_key;
      pay_q <= next_pay;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/skt_reduce.sv =====
// Two-level reduction of the cell flags: boundary position, match, payload.
// First level is registered per group of cells; depends on skt_pkg.
`default_nettype none
module skt_reduce import skt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [CAPACITY-1:0] bnd,
  input  logic [CAPACITY-1:0] eq,
  input  pay_t                pay [CAPACITY],
  output logic                hit,
  output logic [IDX_W-1:0]    pos,
  output pay_t                hit_pay
);

  logic [IDX_W-1:0] g_pos_c [NGRP];
  logic             g_hit_c [NGRP];
  pay_t             g_pay_c [NGRP];
  logic [IDX_W-1:0] g_pos   [NGRP];
  logic             g_hit   [NGRP];
  pay_t             g_pay   [NGRP];

  // per-group OR of the one-hot boundary
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      g_pos_c[g] = '0;
      g_hit_c[g] = 1'b0;
      g_pay_c[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < CAPACITY) begin
          if (bnd[g * GRP + j]) begin
            g_pos_c[g] = g_pos_c[g] | IDX_W'(g * GRP + j);
          end
          if (bnd[g * GRP + j] && eq[g * GRP + j]) begin
            g_hit_c[g] = 1'b1;
            g_pay_c[g] = g_pay_c[g] | pay[g * GRP + j];
          end
        end
      end
    end
  end

  // group results register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NGRP; g++) begin
        g_hit[g] <= 1'b0;
      end
    end else if (load) begin
      for (int g = 0; g < NGRP; g++) begin
        g_hit[g] <= g_hit_c[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NGRP; g++) begin
        g_pos[g] <= g_pos_c[g];
        g_pay[g] <= g_pay_c[g];
      end
    end
  end

  // second level across groups
  always_comb begin
    hit     = 1'b0;
    pos     = '0;
    hit_pay = '0;
    for (int g = 0; g < NGRP; g++) begin
      hit     = hit | g_hit[g];
      pos     = pos | g_pos[g];
      hit_pay = hit_pay | g_pay[g];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_key_table_core.sv =====
// Sorted key table: a row of cells kept in ascending key order.
// Depends on skt_pkg, skt_cell, skt_reduce and sorted_key_table_core_assert.svh.
//
//   channel | direction | handshake           | fields
//   in      | into core | in_valid / in_stall   | action, key, payload
//   out     | from core | out_valid / out_stall | status, position, found_payload,
//           |           |                       | entry_count
//
// Each word passes through accept, compare in every cell, registered group
// reduction, then update of the row and load of the result register.
// The next word is accepted in the cycle after its result is loaded.
// A result waiting under out_stall holds the final step until taken.
// Synchronous reset empties the table at once; no clearing pass.
`default_nettype none
`include "sorted_key_table_core_assert.svh"
module sorted_key_table_core import skt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ACTION_W-1:0]    action,
  input  logic [KEY_W-1:0]       key,
  input  logic [PAY_IN_W-1:0]    payload,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    status,
  output logic [POS_OUT_W-1:0]   position,
  output logic [PAY_IN_W-1:0]    found_payload,
  output logic [COUNT_OUT_W-1:0] entry_count
);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_RED, S_FIN} state_t;

  state_t              state;
  logic [ACTION_W-1:0] op_q;
  key_t                key_q;
  pay_t                pay_q;
  logic [CNT_W-1:0]    count;

  skt_ctrl_t           cell_ctrl;
  logic [CAPACITY-1:0] cell_occ;
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] cell_bnd;
  logic [CAPACITY-1:0] cell_prev_lt;
  key_t                cell_key      [CAPACITY];
  pay_t                cell_pay      [CAPACITY];
  key_t                cell_prev_key [CAPACITY];
  pay_t                cell_prev_pay [CAPACITY];
  key_t                cell_next_key [CAPACITY];
  pay_t                cell_next_pay [CAPACITY];

  logic                red_hit;
  logic [IDX_W-1:0]    red_pos;
  pay_t                red_pay;

  logic                fin_go;
  logic                full;
  logic                ins_ok;
  logic                rem_ok;

  logic [STATUS_W-1:0]    status_next;
  logic [POS_OUT_W-1:0]   position_next;
  logic [PAY_IN_W-1:0]    found_payload_next;
  logic [COUNT_OUT_W-1:0] entry_count_next;
  logic [CNT_W-1:0]       count_next;

  // control decode
  assign in_stall      = rst || (state != S_IDLE);
  assign fin_go        = (state == S_FIN) && (!out_valid || !out_stall);
  assign full          = (count >= CNT_W'(CAPACITY));
  assign ins_ok        = (op_q == ACT_INSERT) && !full;
  assign rem_ok        = (op_q == ACT_REMOVE) && red_hit;
  assign cell_ctrl.cmp = (state == S_CMP);
  assign cell_ctrl.ins = fin_go && ins_ok;
  assign cell_ctrl.rem = fin_go && rem_ok;

  // row of cells with neighbour links
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_occ[i] = (CNT_W'(i) < count);
    if (i == 0) begin : g_first
      assign cell_prev_lt[i]  = 1'b1;
      assign cell_prev_key[i] = key_q;
      assign cell_prev_pay[i] = pay_q;
    end else begin : g_mid
      assign cell_prev_lt[i]  = cell_lt[i-1];
      assign cell_prev_key[i] = cell_key[i-1];
      assign cell_prev_pay[i] = cell_pay[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign cell_next_key[i] = cell_key[i];
      assign cell_next_pay[i] = cell_pay[i];
    end else begin : g_inner
      assign cell_next_key[i] = cell_key[i+1];
      assign cell_next_pay[i] = cell_pay[i+1];
    end

    skt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .occ      (cell_occ[i]),
      .key_new  (key_q),
      .pay_new  (pay_q),
      .prev_lt  (cell_prev_lt[i]),
      .prev_key (cell_prev_key[i]),
      .prev_pay (cell_prev_pay[i]),
      .next_key (cell_next_key[i]),
      .next_pay (cell_next_pay[i]),
      .key_q    (cell_key[i]),
      .pay_q    (cell_pay[i]),
      .lt       (cell_lt[i]),
      .eq       (cell_eq[i]),
      .bnd      (cell_bnd[i])
    );
  end

  // boundary / match reduction
  skt_reduce u_reduce (
    .clk     (clk),
    .rst     (rst),
    .load    (state == S_RED),
    .bnd     (cell_bnd),
    .eq      (cell_eq),
    .pay     (cell_pay),
    .hit     (red_hit),
    .pos     (red_pos),
    .hit_pay (red_pay)
  );

  // result of the operation held in the final step
  always_comb begin
    status_next        = ST_NOTFOUND;
    position_next      = '0;
    found_payload_next = '0;
    count_next         = count;
    unique case (op_q)
      ACT_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next   = ST_OK;
          position_next = POS_OUT_W'(red_pos);
          count_next    = count + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (red_hit) begin
          status_next   = ST_OK;
          position_next = POS_OUT_W'(red_pos);
          count_next    = count - 1'b1;
        end
      end
      ACT_SEARCH: begin
        if (red_hit) begin
          status_next        = ST_OK;
          position_next      = POS_OUT_W'(red_pos);
          found_payload_next = PAY_IN_W'(red_pay);
        end
      end
      default: ;
    endcase
    entry_count_next = COUNT_OUT_W'(count_next);
  end

  // sequencer, table count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= action;
            key_q <= key;
            pay_q <= PAYLOAD_BITS'(payload);
            state <= S_CMP;
          end
        end
        S_CMP: state <= S_RED;
        S_RED: state <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            status        <= status_next;
            position      <= position_next;
            found_payload <= found_payload_next;
            entry_count   <= entry_count_next;
            count         <= count_next;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `SKT_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CNT_W'(CAPACITY))
  `SKT_ASSERT_IMP(a_bnd_onehot, clk, rst, state == S_RED, $onehot0(cell_bnd))
  `SKT_ASSERT_NXT(a_ins_count, clk, rst, cell_ctrl.ins, count == $past(count) + 1'b1)
  `SKT_ASSERT_IMP(a_hit_occupied, clk, rst, state == S_FIN && red_hit, CNT_W'(red_pos) < count)

endmodule
`default_nettype wire

// ===== tb/tb_sorted_key_table_core.sv =====
// Self-checking testbench of the sorted key table core: directed and random table operations.
// Depends on skt_pkg and sorted_key_table_core; a private copy of the table predicts each result.
module tb_sorted_key_table_core;
  import skt_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_WORDS = 1800;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_LIMIT  = 100;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [POS_OUT_W-1:0]   position;
    logic [PAY_IN_W-1:0]    found_payload;
    logic [COUNT_OUT_W-1:0] entry_count;
  } table_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [ACTION_W-1:0]    action = ACT_INSERT;
  logic [KEY_W-1:0]       key = '0;
  logic [PAY_IN_W-1:0]    payload = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [POS_OUT_W-1:0]   position;
  logic [PAY_IN_W-1:0]    found_payload;
  logic [COUNT_OUT_W-1:0] entry_count;

  // Private copy of the table, updated as each word is accepted
  key_t tbl_key [CAPACITY];
  pay_t tbl_pay [CAPACITY];
  int   tbl_count = 0;

  table_result_t pending_results[$];

  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  // Operation statistics for the closing summary
  int n_insert = 0;
  int n_full = 0;
  int n_remove_hit = 0;
  int n_search_hit = 0;
  int n_miss = 0;
  int n_unused = 0;
  int peak_count = 0;

  sorted_key_table_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .key           (key),
    .payload       (payload),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .position      (position),
    .found_payload (found_payload),
    .entry_count   (entry_count)
  );

  // Clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones; none at all when calm
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Predict one operation and update the private table
  function automatic table_result_t table_apply(input logic [ACTION_W-1:0] act, input key_t k,
                                                input logic [PAY_IN_W-1:0] pay);
    table_result_t res;
    int i;
    int slot;
    int hit_slot;
    res = '{status: ST_NOTFOUND, position: '0, found_payload: '0, entry_count: '0};
    hit_slot = -1;
    for (i = 0; i < tbl_count; i++)
      if (hit_slot < 0 && tbl_key[i] == k) hit_slot = i;
    case (act)
      ACT_INSERT: begin
        if (tbl_count >= CAPACITY) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          slot = 0;
          while (slot < tbl_count && tbl_key[slot] < k) slot++;
          for (i = tbl_count; i > slot; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_pay[i] = tbl_pay[i-1];
          end
          tbl_key[slot] = k;
          tbl_pay[slot] = pay_t'(pay);
          tbl_count++;
          res.status = ST_OK;
          res.position = POS_OUT_W'(slot);
          n_insert++;
        end
      end
      ACT_REMOVE: begin
        if (hit_slot >= 0) begin
          for (i = hit_slot; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_pay[i] = tbl_pay[i+1];
          end
          tbl_count--;
          res.status = ST_OK;
          res.position = POS_OUT_W'(hit_slot);
          n_remove_hit++;
        end else begin
          n_miss++;
        end
      end
      ACT_SEARCH: begin
        if (hit_slot >= 0) begin
          res.status = ST_OK;
          res.position = POS_OUT_W'(hit_slot);
          res.found_payload = PAY_IN_W'(tbl_pay[hit_slot]);
          n_search_hit++;
        end else begin
          n_miss++;
        end
      end
      default: n_unused++;
    endcase
    if (tbl_count > peak_count) peak_count = tbl_count;
    res.entry_count = COUNT_OUT_W'(tbl_count);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got_val,
                                 input logic [63:0] want_val);
    if (errors < PRINT_LIMIT)
      $display("mismatch: %s on result %0d: got %0h, want %0h", what, words_out, got_val,
               want_val);
    errors++;
  endtask

  // Receiver stall pattern, changed on the falling edge
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      stall_left = pick_gap(rx_calm);
    end
  end

  // Check each result against the oldest prediction, then predict any accepted word
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(status), 64'(ST_OK));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", 64'(status), 64'(want.status));
        if (position !== want.position)
          report_mismatch("position", 64'(position), 64'(want.position));
        if (found_payload !== want.found_payload)
          report_mismatch("found_payload", 64'(found_payload), 64'(want.found_payload));
        if (entry_count !== want.entry_count)
          report_mismatch("entry_count", 64'(entry_count), 64'(want.entry_count));
      end
      words_out++;
    end
    if (!rst && in_valid && !in_stall) begin
      pending_results.push_back(table_apply(action, key, payload));
      words_in++;
    end
  end

  // Watchdog: too long with no word moving on either side
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Offer one word and hold it until taken
  task automatic send_word(input logic [ACTION_W-1:0] act, input key_t k,
                           input logic [PAY_IN_W-1:0] pay);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action = act;
    key = k;
    payload = pay;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Keys: mostly ones held in the table or next to them, some tiny, extreme or wide random
  function automatic key_t pick_key();
    int r;
    key_t k;
    r = $urandom_range(0, 99);
    if (tbl_count > 0 && r < 55) return tbl_key[$urandom_range(0, tbl_count - 1)];
    if (tbl_count > 0 && r < 65) begin
      k = tbl_key[$urandom_range(0, tbl_count - 1)];
      return $urandom_range(0, 1) ? k + key_t'(1) : k - key_t'(1);
    end
    if (r < 75) return key_t'($urandom_range(0, 15));
    if (r < 82) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return key_t'(1);
        default: return ~key_t'(1);
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ACTION_W-1:0] pick_action(input int ins_w, input int rem_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return ACT_UNUSED;
    r = $urandom_range(0, 99);
    if (r < ins_w) return ACT_INSERT;
    if (r < ins_w + rem_w) return ACT_REMOVE;
    return ACT_SEARCH;
  endfunction

  // Misses and the unused action on an empty table, then a first entry
  task automatic test_empty_table();
    send_word(ACT_SEARCH, '0, 16'h0000);
    send_word(ACT_REMOVE, '1, 16'hffff);
    send_word(ACT_UNUSED, 64'h0123_4567_89ab_cdef, 16'h1234);
    send_word(ACT_INSERT, '0, 16'h0000);
    send_word(ACT_SEARCH, '0, 16'hffff);
  endtask

  // Lowest, highest and top-bit keys, with full-range payloads
  task automatic test_key_extremes();
    send_word(ACT_INSERT, '1, 16'hffff);
    send_word(ACT_INSERT, 64'h8000_0000_0000_0000, 16'h8001);
    send_word(ACT_SEARCH, '1, 16'h0000);
    send_word(ACT_REMOVE, '0, 16'h0000);
    send_word(ACT_SEARCH, 64'h8000_0000_0000_0000, 16'h0000);
  endtask

  // Equal keys: a new one goes before the old, search and remove take the first
  task automatic test_duplicates();
    send_word(ACT_INSERT, 64'h4142_4300_0000_0000, 16'h5555);
    send_word(ACT_INSERT, 64'h4142_4300_0000_0000, 16'haaaa);
    send_word(ACT_SEARCH, 64'h4142_4300_0000_0000, 16'h0000);
    send_word(ACT_REMOVE, 64'h4142_4300_0000_0000, 16'h0000);
    send_word(ACT_SEARCH, 64'h4142_4300_0000_0000, 16'h0000);
  endtask

  // Unused action on a populated table leaves it alone
  task automatic test_unused_action();
    send_word(ACT_UNUSED, '1, 16'hffff);
    send_word(ACT_SEARCH, '1, 16'h0000);
  endtask

  // Phases that fill, churn and drain the table, so that inserts also meet a full table
  task automatic test_random_phases();
    int sent;
    int len;
    int phase;
    int i;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      len = $urandom_range(100, 250);
      for (i = 0; i < len; i++) begin
        case (phase % 4)
          0: send_word(pick_action(80, 10), pick_key(), PAY_IN_W'($urandom));
          2: send_word(pick_action(15, 70), pick_key(), PAY_IN_W'($urandom));
          default: send_word(pick_action(40, 30), pick_key(), PAY_IN_W'($urandom));
        endcase
      end
      sent += len;
      // hold the sender until every result is back
      wait_results();
      phase++;
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_empty_table();
    test_key_extremes();
    test_duplicates();
    test_unused_action();
    test_random_phases();
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("summary: %0d words in, %0d results, %0d inserts, %0d refused as full",
             words_in, words_out, n_insert, n_full);
    $display("summary: %0d removes and %0d searches hit, %0d misses, %0d unused, peak %0d",
             n_remove_hit, n_search_hit, n_miss, n_unused, peak_count);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
